// ===== src/peu_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the particle
// integrate/bounce pipeline. No dependencies.
`timescale 1ns / 1ps
package peu_pkg;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_TIME       = 4'd0,
      REG_MAX_SPEED       = 4'd1,
      REG_BOUNCE_DAMPING  = 4'd2,
      REG_LOWER_X         = 4'd3,
      REG_LOWER_Y         = 4'd4,
      REG_UPPER_X         = 4'd5,
      REG_UPPER_Y         = 4'd6,
      REG_PARTICLE_RADIUS = 4'd7
   } peu_reg_type;

   // particle state carried down the pipe
   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               over;
   } peu_kin_type;

   // square root recurrence, one root bit per cell
   typedef struct packed {
      logic [63:0] rad;
      logic [32:0] rem;
      logic [31:0] root;
   } peu_sqrt_type;

   // restoring division of both axes by the same length
   typedef struct packed {
      logic [31:0] len;
      logic [31:0] rem_x;
      logic [30:0] low_x;
      logic [30:0] quo_x;
      logic [31:0] rem_y;
      logic [30:0] low_y;
      logic [30:0] quo_y;
   } peu_div_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) r = 32'sh7fffffff;
      else if (v < -35'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // (p + 2^23) >> 24, floor
   function automatic logic signed [33:0] round_dt(input logic signed [56:0] p);
      logic signed [57:0] t;
      t = {p[56], p} + 58'sd8388608;
      return t[57:24];
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

endpackage

// ===== src/peu_if.sv =====
// Request, response and register-write channel interfaces.
// Depends on nothing.
`timescale 1ns / 1ps
interface peu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, input ready);
   modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, output ready);
endinterface

interface peu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
endinterface

interface peu_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/peu_sqrt_cell.sv =====
// One square root cell: retires one root bit and hands the particle on.
// Depends on peu_pkg.
`timescale 1ns / 1ps
module peu_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  peu_pkg::peu_kin_type  in_kin,
   input  peu_pkg::peu_sqrt_type in_data,
   output logic                  out_valid,
   output peu_pkg::peu_kin_type  out_kin,
   output peu_pkg::peu_sqrt_type out_data
);
   import peu_pkg::*;

   logic         valid_ff;
   peu_kin_type  kin_ff;
   peu_sqrt_type data_ff, data_in;
   logic [34:0]  rem2, trial;
   logic         ge;

   always_comb begin
      rem2  = {in_data.rem, in_data.rad[63:62]};
      trial = {1'b0, in_data.root, 2'b01};
      ge    = rem2 >= trial;
      data_in.rem  = ge ? 33'(rem2 - trial) : rem2[32:0];
      data_in.root = {in_data.root[30:0], ge};
      data_in.rad  = {in_data.rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         kin_ff  <= in_kin;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kin   = kin_ff;
   assign out_data  = data_ff;
endmodule

// ===== src/peu_div_cell.sv =====
// One divider cell: one quotient bit for each axis, particle handed on.
// Depends on peu_pkg.
`timescale 1ns / 1ps
module peu_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  peu_pkg::peu_kin_type in_kin,
   input  peu_pkg::peu_div_type in_data,
   output logic                 out_valid,
   output peu_pkg::peu_kin_type out_kin,
   output peu_pkg::peu_div_type out_data
);
   import peu_pkg::*;

   logic        valid_ff;
   peu_kin_type kin_ff;
   peu_div_type data_ff, data_in;
   logic [32:0] rem2_x, rem2_y, den;
   logic        ge_x, ge_y;

   always_comb begin
      den    = {1'b0, in_data.len};
      rem2_x = {in_data.rem_x, in_data.low_x[30]};
      rem2_y = {in_data.rem_y, in_data.low_y[30]};
      ge_x   = rem2_x >= den;
      ge_y   = rem2_y >= den;
      data_in.len   = in_data.len;
      data_in.rem_x = ge_x ? 32'(rem2_x - den) : rem2_x[31:0];
      data_in.rem_y = ge_y ? 32'(rem2_y - den) : rem2_y[31:0];
      data_in.low_x = {in_data.low_x[29:0], 1'b0};
      data_in.low_y = {in_data.low_y[29:0], 1'b0};
      data_in.quo_x = {in_data.quo_x[29:0], ge_x};
      data_in.quo_y = {in_data.quo_y[29:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         kin_ff  <= in_kin;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kin   = kin_ff;
   assign out_data  = data_ff;
endmodule

// ===== src/peu_wall.sv =====
// Wall clamp and damped reflection for one axis, one register stage.
// Depends on peu_pkg.
`timescale 1ns / 1ps
module peu_wall (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  logic signed [31:0] pos,
   input  logic signed [31:0] vel,
   input  logic signed [31:0] lower,
   input  logic signed [31:0] upper,
   input  logic [30:0]        radius,
   input  logic [16:0]        damping,
   output logic               out_valid,
   output logic signed [31:0] out_pos,
   output logic signed [31:0] out_vel
);
   import peu_pkg::*;

   logic               valid_ff;
   logic signed [32:0] lo_in, hi_in, lo_ff, hi_ff;
   logic               below_in, above_in, below_ff, above_ff;
   logic [48:0]        prod_in, prod_ff;
   logic signed [31:0] pos_ff, vel_ff;
   logic [49:0]        rnd;
   logic [33:0]        mag_d;

   always_comb begin
      lo_in    = {lower[31], lower} + $signed({2'b00, radius});
      hi_in    = {upper[31], upper} - $signed({2'b00, radius});
      below_in = $signed({pos[31], pos}) < lo_in;
      // lower test wins on an inverted box
      above_in = !below_in && ($signed({pos[31], pos}) > hi_in);
      prod_in  = 49'(abs32(vel)) * 49'(damping);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         below_ff <= below_in;
         above_ff <= above_in;
         prod_ff  <= prod_in;
         pos_ff   <= pos;
         vel_ff   <= vel;
      end
   end

   always_comb begin
      rnd     = {1'b0, prod_ff} + 50'd32768;
      mag_d   = rnd[49:16];
      out_pos = pos_ff;
      out_vel = vel_ff;
      if (below_ff) begin
         out_pos = sat32({{2{lo_ff[32]}}, lo_ff});
         if (vel_ff[31]) out_vel = sat32($signed({1'b0, mag_d}));
      end else if (above_ff) begin
         out_pos = sat32({{2{hi_ff[32]}}, hi_ff});
         if (!vel_ff[31] && vel_ff != 32'sd0) out_vel = sat32(-$signed({1'b0, mag_d}));
      end
   end

   assign out_valid = valid_ff;
endmodule

// ===== src/particle_euler_integrate_bounce_unit.sv =====
// Particle Euler step with speed limit and wall bounce, one request per cycle
// whenever the pipe is not stalled.
// The speed limit runs through a 32-cell square root row and a 31-cell divider row.
// Back pressure stalls only when a result waits on a full, unread response register.
// Synchronous active-high reset clears all valid bits and loads register defaults.
// Depends on peu_pkg, peu_if, peu_sqrt_cell, peu_div_cell, peu_wall.
`timescale 1ns / 1ps
module particle_euler_integrate_bounce_unit (
   input  logic       clock,
   input  logic       reset,
   peu_req_if.sink    req_chan,
   peu_rsp_if.source  rsp_chan,
   peu_csr_if.sink    csr_chan
);
   import peu_pkg::*;

   localparam int SQ_N  = 32;
   localparam int DIV_N = 31;

   // configuration registers
   logic [23:0]        step_time_ff;
   logic [30:0]        max_speed_ff;
   logic [16:0]        damping_ff;
   logic signed [31:0] lower_x_ff, lower_y_ff, upper_x_ff, upper_y_ff;
   logic [30:0]        radius_ff;
   logic [61:0]        ms_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= 24'd167772;
         max_speed_ff <= 31'd0;
         damping_ff   <= 17'd32768;
         lower_x_ff   <= 32'sd0;
         lower_y_ff   <= 32'sd0;
         upper_x_ff   <= 32'sd65536;
         upper_y_ff   <= 32'sd65536;
         radius_ff    <= 31'd0;
      end else if (csr_chan.valid) begin
         unique case (peu_reg_type'(csr_chan.index))
            REG_STEP_TIME:       step_time_ff <= csr_chan.data[23:0];
            REG_MAX_SPEED:       max_speed_ff <= csr_chan.data[30:0];
            REG_BOUNCE_DAMPING:  damping_ff   <= csr_chan.data[16:0];
            REG_LOWER_X:         lower_x_ff   <= csr_chan.data;
            REG_LOWER_Y:         lower_y_ff   <= csr_chan.data;
            REG_UPPER_X:         upper_x_ff   <= csr_chan.data;
            REG_UPPER_Y:         upper_y_ff   <= csr_chan.data;
            REG_PARTICLE_RADIUS: radius_ff    <= csr_chan.data[30:0];
            default: ;
         endcase
      end
      ms_sq_ff <= 62'(max_speed_ff) * 62'(max_speed_ff);
   end

   assign csr_chan.ready = 1'b1;

   // pipe advance: output register free, or nothing arriving at it
   logic out_free, adv;
   logic wall_valid_x, wall_valid_y;
   logic rsp_valid_ff;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign adv            = out_free || !wall_valid_x;
   assign req_chan.ready = adv;

   // stage 1: acceleration times step
   logic               v1_ff;
   peu_kin_type        kin1_ff, kin1_in;
   logic signed [56:0] pax1_ff, pay1_ff;
   always_comb begin
      kin1_in.px   = req_chan.pos_x;
      kin1_in.py   = req_chan.pos_y;
      kin1_in.vx   = req_chan.vel_x;
      kin1_in.vy   = req_chan.vel_y;
      kin1_in.over = 1'b0;
   end

   // stage 2: velocity update
   logic        v2_ff;
   peu_kin_type kin2_ff, kin2_in;
   always_comb begin
      kin2_in    = kin1_ff;
      kin2_in.vx = sat32(35'(kin1_ff.vx) + 35'(round_dt(pax1_ff)));
      kin2_in.vy = sat32(35'(kin1_ff.vy) + 35'(round_dt(pay1_ff)));
   end

   // stage 3: squared components
   logic        v3_ff;
   peu_kin_type kin3_ff;
   logic [63:0] sqx3_ff, sqy3_ff;

   // stage 4: squared length and limit test, feeds the root row
   logic [63:0]  len2;
   peu_kin_type  kin4_in;
   peu_sqrt_type sq4_in;
   always_comb begin
      len2         = sqx3_ff + sqy3_ff;
      kin4_in      = kin3_ff;
      kin4_in.over = (max_speed_ff != 31'd0) && (len2 > {2'b00, ms_sq_ff});
      sq4_in.rad   = len2;
      sq4_in.rem   = 33'd0;
      sq4_in.root  = 32'd0;
   end

   logic         sq_valid [0:SQ_N];
   peu_kin_type  sq_kin   [0:SQ_N];
   peu_sqrt_type sq_data  [0:SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         sq_valid[0] <= 1'b0;
      end else if (adv) begin
         v1_ff       <= req_chan.valid;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         sq_valid[0] <= v3_ff;
      end
      if (adv) begin
         kin1_ff    <= kin1_in;
         pax1_ff    <= 57'(req_chan.acc_x) * 57'($signed({1'b0, step_time_ff}));
         pay1_ff    <= 57'(req_chan.acc_y) * 57'($signed({1'b0, step_time_ff}));
         kin2_ff    <= kin2_in;
         kin3_ff    <= kin2_ff;
         sqx3_ff    <= 64'(abs32(kin2_ff.vx)) * 64'(abs32(kin2_ff.vx));
         sqy3_ff    <= 64'(abs32(kin2_ff.vy)) * 64'(abs32(kin2_ff.vy));
         sq_kin[0]  <= kin4_in;
         sq_data[0] <= sq4_in;
      end
   end

   for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
      peu_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .in_valid (sq_valid[i]),
         .in_kin   (sq_kin[i]),
         .in_data  (sq_data[i]),
         .out_valid(sq_valid[i+1]),
         .out_kin  (sq_kin[i+1]),
         .out_data (sq_data[i+1])
      );
   end

   // numerator stage: |v| * limit, split into remainder head and tail
   logic [62:0] num_x, num_y;
   peu_div_type dv0_in;
   always_comb begin
      num_x        = 63'(abs32(sq_kin[SQ_N].vx)) * 63'(max_speed_ff);
      num_y        = 63'(abs32(sq_kin[SQ_N].vy)) * 63'(max_speed_ff);
      dv0_in.len   = sq_data[SQ_N].root;
      dv0_in.rem_x = num_x[62:31];
      dv0_in.low_x = num_x[30:0];
      dv0_in.quo_x = 31'd0;
      dv0_in.rem_y = num_y[62:31];
      dv0_in.low_y = num_y[30:0];
      dv0_in.quo_y = 31'd0;
   end

   logic        dv_valid [0:DIV_N];
   peu_kin_type dv_kin   [0:DIV_N];
   peu_div_type dv_data  [0:DIV_N];

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      peu_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .in_valid (dv_valid[j]),
         .in_kin   (dv_kin[j]),
         .in_data  (dv_data[j]),
         .out_valid(dv_valid[j+1]),
         .out_kin  (dv_kin[j+1]),
         .out_data (dv_data[j+1])
      );
   end

   // sign stage: rescaled velocity
   logic        v6_ff;
   peu_kin_type kin6_ff, kin6_in;
   logic [31:0] qx, qy;
   always_comb begin
      qx      = {1'b0, dv_data[DIV_N].quo_x};
      qy      = {1'b0, dv_data[DIV_N].quo_y};
      kin6_in = dv_kin[DIV_N];
      if (dv_kin[DIV_N].over) begin
         kin6_in.vx = dv_kin[DIV_N].vx[31] ? -$signed(qx) : $signed(qx);
         kin6_in.vy = dv_kin[DIV_N].vy[31] ? -$signed(qy) : $signed(qy);
      end
   end

   // stage 7: velocity times step, stage 8: position update
   logic               v7_ff, v8_ff;
   peu_kin_type        kin7_ff, kin8_ff, kin8_in;
   logic signed [56:0] pvx7_ff, pvy7_ff;
   always_comb begin
      kin8_in    = kin7_ff;
      kin8_in.px = sat32(35'(kin7_ff.px) + 35'(round_dt(pvx7_ff)));
      kin8_in.py = sat32(35'(kin7_ff.py) + 35'(round_dt(pvy7_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid[0] <= 1'b0;
         v6_ff       <= 1'b0;
         v7_ff       <= 1'b0;
         v8_ff       <= 1'b0;
      end else if (adv) begin
         dv_valid[0] <= sq_valid[SQ_N];
         v6_ff       <= dv_valid[DIV_N];
         v7_ff       <= v6_ff;
         v8_ff       <= v7_ff;
      end
      if (adv) begin
         dv_kin[0]  <= sq_kin[SQ_N];
         dv_data[0] <= dv0_in;
         kin6_ff    <= kin6_in;
         kin7_ff    <= kin6_ff;
         pvx7_ff    <= 57'(kin6_ff.vx) * 57'($signed({1'b0, step_time_ff}));
         pvy7_ff    <= 57'(kin6_ff.vy) * 57'($signed({1'b0, step_time_ff}));
         kin8_ff    <= kin8_in;
      end
   end

   logic signed [31:0] wpx, wvx, wpy, wvy;

   peu_wall u_wall_x (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (v8_ff),
      .pos      (kin8_ff.px),
      .vel      (kin8_ff.vx),
      .lower    (lower_x_ff),
      .upper    (upper_x_ff),
      .radius   (radius_ff),
      .damping  (damping_ff),
      .out_valid(wall_valid_x),
      .out_pos  (wpx),
      .out_vel  (wvx)
   );

   peu_wall u_wall_y (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (v8_ff),
      .pos      (kin8_ff.py),
      .vel      (kin8_ff.vy),
      .lower    (lower_y_ff),
      .upper    (upper_y_ff),
      .radius   (radius_ff),
      .damping  (damping_ff),
      .out_valid(wall_valid_y),
      .out_pos  (wpy),
      .out_vel  (wvy)
   );

   // response register
   logic signed [31:0] rpx_ff, rpy_ff, rvx_ff, rvy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= wall_valid_x;
      end
      if (out_free) begin
         rpx_ff <= wpx;
         rpy_ff <= wpy;
         rvx_ff <= wvx;
         rvy_ff <= wvy;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.new_pos_x = rpx_ff;
   assign rsp_chan.new_pos_y = rpy_ff;
   assign rsp_chan.new_vel_x = rvx_ff;
   assign rsp_chan.new_vel_y = rvy_ff;

`ifndef NO_ASSERTIONS
   // a stall only happens with a full response register and a request behind it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (rsp_valid_ff && wall_valid_x))
      else $error("pipe stalled without a waiting response");

   // both wall lanes move in lock step
   a_wall_lanes: assert property (@(posedge clock) disable iff (reset)
      wall_valid_x == wall_valid_y)
      else $error("wall lanes out of step");

   // rescaled magnitude never exceeds the limit
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_valid[DIV_N] && dv_kin[DIV_N].over) |->
         ({1'b0, dv_data[DIV_N].quo_x} <= {1'b0, max_speed_ff} &&
          {1'b0, dv_data[DIV_N].quo_y} <= {1'b0, max_speed_ff}))
      else $error("rescaled speed above limit");

   // limit flag only with the limit enabled
   a_over_enabled: assert property (@(posedge clock) disable iff (reset)
      (sq_valid[0] && sq_kin[0].over) |-> (max_speed_ff != 31'd0))
      else $error("speed limit flagged while disabled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
`endif
endmodule
